>>> hw/rtl/mhpq_pkg.sv
// shared types and constants for the max-heap priority queue
// no dependencies; imported by the top level, the checker and the testbench

package mhpq_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 9;
    localparam int CAP_W   = 9;
    localparam int STAT_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic                    op;
        logic signed [KEY_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] popped_value;
        logic signed [KEY_W-1:0] top_value;
        logic [COUNT_W-1:0]      count;
        logic [STAT_W-1:0]       status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

endpackage

>>> hw/rtl/max_heap_priority_queue.sv
// top level of the binary max-heap priority queue of signed 32-bit keys
// depends on mhpq_pkg and mhpq_ram
//
// usage:
//   s_valid/s_ready/s_data carry one item: op (insert or extract) and a key.
//   m_valid/m_ready/m_data return one result per item: popped key, current
//   maximum, count and status (ok, insert dropped when full, extract on empty).
//   cfg_valid/cfg_ready/cfg_data write the capacity register (reset 256);
//   capacity above DEPTH acts as DEPTH. write it only while the block is idle.
// operation:
//   one item at a time. the keys sit in two mirrored ram copies with registered
//   reads; each heap level takes a read state and a compare/write state. a
//   dropped insert, an empty extract or a one-key extract goes straight to the result.
// reset:
//   synchronous, active low. the heap is empty and capacity returns to 256;
//   ram contents are not cleared since positions beyond the held count are never used.
// stall:
//   the finished result waits in the output register; a new item is accepted
//   while it waits, and the next result is held back until the slot is free.

module max_heap_priority_queue #(
    parameter int DEPTH = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mhpq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mhpq_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [8:0]          cfg_data
);

    import mhpq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           fill_reg, fill_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] popped_reg, popped_next;
    logic signed [KEY_W-1:0] root_reg, root_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic [CAP_W-1:0]        cap_reg;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr_a, rd_addr_b;
    logic [KEY_W-1:0] rd_data_a, rd_data_b;

    logic                    is_full;
    logic [CW:0]             left_pos, right_pos, child_pos;
    logic                    right_ok, pick_right;
    logic signed [KEY_W-1:0] child_val;

    mhpq_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram_left (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    mhpq_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram_right (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    assign is_full = (CMPW'(fill_reg) >= CMPW'(cap_reg)) || (fill_reg >= CW'(DEPTH));

    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = {pos_reg, 1'b1};
    assign right_ok   = right_pos <= {1'b0, fill_reg};
    assign pick_right = right_ok && !($signed(rd_data_a) > $signed(rd_data_b));
    assign child_val  = pick_right ? $signed(rd_data_b) : $signed(rd_data_a);
    assign child_pos  = pick_right ? right_pos : left_pos;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            cap_reg     <= CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        popped_reg <= popped_next;
        root_reg   <= root_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        rd_addr_a    = '0;
        rd_addr_b    = '0;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    popped_next = '0;
                    status_next = STATUS_OK;
                    if (s_data.op == OP_INSERT) begin
                        if (is_full) begin
                            status_next = STATUS_FULL;
                            state_next  = ST_FINISH;
                        end else begin
                            fill_next  = fill_reg + CW'(1);
                            pos_next   = fill_reg + CW'(1);
                            key_next   = s_data.value;
                            state_next = ST_UP;
                        end
                    end else begin
                        if (fill_reg == '0) begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_FINISH;
                        end else begin
                            popped_next = root_reg;
                            fill_next   = fill_reg - CW'(1);
                            if (fill_reg == CW'(1)) begin
                                state_next = ST_FINISH;
                            end else begin
                                rd_addr_a  = AW'(fill_reg - CW'(1));
                                pos_next   = CW'(1);
                                state_next = ST_DN_LAST;
                            end
                        end
                    end
                end
            end
            ST_UP: begin
                if (pos_reg == CW'(1)) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = key_reg;
                    state_next = ST_FINISH;
                end else begin
                    rd_addr_a  = AW'((pos_reg >> 1) - CW'(1));
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg - CW'(1));
                if (key_reg > $signed(rd_data_a)) begin
                    wr_data    = rd_data_a;
                    pos_next   = pos_reg >> 1;
                    state_next = ST_UP;
                end else begin
                    wr_data    = key_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_DN_LAST: begin
                key_next   = rd_data_a;
                state_next = ST_DN;
            end
            ST_DN: begin
                if (left_pos > {1'b0, fill_reg}) begin
                    wr_en      = 1'b1;
                    wr_addr    = AW'(pos_reg - CW'(1));
                    wr_data    = key_reg;
                    state_next = ST_FINISH;
                end else begin
                    rd_addr_a  = AW'(left_pos - (CW + 1)'(1));
                    rd_addr_b  = AW'(left_pos);
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg - CW'(1));
                if (child_val > key_reg) begin
                    wr_data    = child_val;
                    pos_next   = CW'(child_pos);
                    state_next = ST_DN;
                end else begin
                    wr_data    = key_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.popped_value  = popped_reg;
                    m_data_next.top_value     = (fill_reg != '0) ? root_reg : '0;
                    m_data_next.count         = COUNT_W'(fill_reg);
                    m_data_next.status        = status_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // mirror of heap position one for the top output and extract
    always_comb begin
        root_next = root_reg;
        if (wr_en && wr_addr == '0) begin
            root_next = wr_data;
        end
    end

endmodule

>>> hw/rtl/mhpq_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies

module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/mhpq_checker.sv
// port-level checks for the max-heap priority queue
// depends on mhpq_pkg; bound to max_heap_priority_queue below

module mhpq_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input mhpq_pkg::out_item_t m_data
);

    import mhpq_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing is pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // extract on empty reports an empty heap
    a_empty_extract: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_EMPTY |->
            m_data.count == '0 && m_data.popped_value == '0 && m_data.top_value == '0)
        else $error("empty extract with nonzero fields");

    // an empty heap shows no maximum
    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.count == '0 |-> m_data.top_value == '0)
        else $error("top value nonzero on empty heap");

    // dropped insert never pops
    a_full_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_FULL |-> m_data.popped_value == '0)
        else $error("dropped insert reports a popped key");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

>>> sim/max_heap_priority_queue_tb.sv
// self-checking testbench for max_heap_priority_queue: directed table, then random phases
// depends on mhpq_pkg and the max_heap_priority_queue rtl; keeps its own heap model
`timescale 1ns / 100ps

module max_heap_priority_queue_tb;

    import mhpq_pkg::*;

    localparam int HEAP_DEPTH     = 256;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_REPORTS    = 40;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    typedef struct {
        bit               is_cfg;
        logic [CAP_W-1:0] cap;
        in_item_t         item;
        bit               typed;
        out_item_t        result;
    } stim_row_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    logic signed [KEY_W-1:0] heap_keys [1:HEAP_DEPTH];
    int unsigned             held_count       = 0;
    logic [CAP_W-1:0]        capacity_setting = CAP_RESET;

    out_item_t   expected_q [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          tx_idle_pct    = 0;
    int          rx_stall_pct   = 0;
    logic        pressure_on    = 1'b0;
    int          hold_count     = 0;

    max_heap_priority_queue #(
        .DEPTH(HEAP_DEPTH)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic out_item_t predict_heap_op(input in_item_t item);
        out_item_t               res;
        int unsigned             limit;
        int unsigned             pos;
        int unsigned             pick;
        logic signed [KEY_W-1:0] tmp;
        res = '0;
        res.status = STATUS_OK;
        limit = (capacity_setting > HEAP_DEPTH) ? HEAP_DEPTH : capacity_setting;
        if (item.op == OP_INSERT) begin
            if (held_count >= limit) begin
                res.status = STATUS_FULL;
            end else begin
                held_count++;
                heap_keys[held_count] = item.value;
                pos = held_count;
                while (pos > 1) begin
                    if (heap_keys[pos] > heap_keys[pos / 2]) begin
                        tmp = heap_keys[pos];
                        heap_keys[pos] = heap_keys[pos / 2];
                        heap_keys[pos / 2] = tmp;
                    end
                    pos = pos / 2;
                end
            end
        end else begin
            if (held_count == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.popped_value = heap_keys[1];
                heap_keys[1] = heap_keys[held_count];
                held_count--;
                pos = 1;
                while (pos * 2 <= held_count) begin
                    pick = pos * 2;
                    if (pick + 1 <= held_count && !(heap_keys[pick] > heap_keys[pick + 1]))
                        pick = pick + 1;
                    if (!(heap_keys[pick] > heap_keys[pos]))
                        break;
                    tmp = heap_keys[pos];
                    heap_keys[pos] = heap_keys[pick];
                    heap_keys[pick] = tmp;
                    pos = pick;
                end
            end
        end
        res.top_value = (held_count > 0) ? heap_keys[1] : '0;
        res.count = held_count[COUNT_W-1:0];
        return res;
    endfunction

    function automatic void add_item(input logic op, input logic signed [KEY_W-1:0] key);
        stim_row_t row;
        row = '{is_cfg: 1'b0, cap: '0, item: '{op: op, value: key}, typed: 1'b0, result: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic op, input logic signed [KEY_W-1:0] key,
                                        input logic signed [KEY_W-1:0] popped,
                                        input logic signed [KEY_W-1:0] top,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [STAT_W-1:0] status);
        stim_row_t row;
        row = '{is_cfg: 1'b0, cap: '0, item: '{op: op, value: key}, typed: 1'b1,
                result: '{popped_value: popped, top_value: top, count: cnt, status: status}};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cap(input logic [CAP_W-1:0] cap);
        stim_row_t row;
        row = '{is_cfg: 1'b1, cap: cap, item: '0, typed: 1'b0, result: '0};
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [KEY_W-1:0] random_key();
        logic signed [KEY_W-1:0] key;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: key = KEY_MAX;
                    1: key = KEY_MIN;
                    2: key = '0;
                    3: key = -1;
                    default: key = 1;
                endcase
            end
            1: key = int'($urandom_range(0, 15)) - 8;
            default: key = $urandom;
        endcase
        return key;
    endfunction

    function automatic in_item_t random_item(input int insert_pct);
        in_item_t item;
        item.op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT;
        item.value = random_key();
        return item;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] got,
                               input logic [KEY_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic send_item(input in_item_t item, input bit typed, input out_item_t result);
        out_item_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            s_data  <= random_item(50);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = predict_heap_op(item);
        expected_q.push_back(typed ? result : predicted);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        capacity_setting = cap;
    endtask

    task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int tx_pct,
                                    input int rx_pct, input int n_items, input int insert_pct);
        wait_drained();
        write_capacity(cap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (n_items)
            send_item(random_item(insert_pct), 1'b0, '0);
    endtask

    // result side: random stalls, plus one long hold while the input keeps coming
    always @(posedge aclk) begin
        if (pressure_on && hold_count < HOLD_CYCLES) begin
            m_ready    <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            if (!pressure_on)
                hold_count <= 0;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want = expected_q.pop_front();
                check_field("popped_value", m_data.popped_value, want.popped_value);
                check_field("top_value", m_data.top_value, want.top_value);
                check_field("count", m_data.count, want.count);
                check_field("status", m_data.status, want.status);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        add_checked(OP_EXTRACT, 32'sd0, '0, '0, 9'd0, STATUS_EMPTY);
        add_checked(OP_INSERT, KEY_MAX, '0, KEY_MAX, 9'd1, STATUS_OK);
        add_checked(OP_INSERT, KEY_MIN, '0, KEY_MAX, 9'd2, STATUS_OK);
        add_item(OP_INSERT, 32'sd0);
        add_item(OP_INSERT, -32'sd1);
        add_item(OP_INSERT, 32'sd5);
        add_item(OP_INSERT, 32'sd5);
        add_item(OP_INSERT, 32'sh5555_5555);
        add_item(OP_INSERT, 32'shAAAA_AAAA);
        add_checked(OP_EXTRACT, KEY_MIN, KEY_MAX, 32'sh5555_5555, 9'd7, STATUS_OK);
        repeat (7)
            add_item(OP_EXTRACT, KEY_MAX);
        add_checked(OP_EXTRACT, -32'sd1, '0, '0, 9'd0, STATUS_EMPTY);
        add_cap(9'd0);
        add_checked(OP_INSERT, 32'sd7, '0, '0, 9'd0, STATUS_FULL);
        add_cap(9'd1);
        add_checked(OP_INSERT, -32'sd5, '0, -32'sd5, 9'd1, STATUS_OK);
        add_checked(OP_INSERT, 32'sd9, '0, -32'sd5, 9'd1, STATUS_FULL);
        add_cap(9'd511);
        add_item(OP_INSERT, 32'sd9);
        add_item(OP_EXTRACT, 32'sd0);
        add_item(OP_EXTRACT, 32'sd0);

        repeat (9)
            @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_drained();
                write_capacity(directed_rows[i].cap);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].result);
            end
        end

        // fill to the top, then lower capacity below the held count
        run_random_phase(9'd256, 0, 0, 300, 95);
        run_random_phase(9'd4, 65, 0, 100, 20);
        run_random_phase(9'd256, 0, 65, 300, 10);
        run_random_phase(9'd511, 32, 32, 300, 95);
        run_random_phase(9'd17, 65, 0, 200, 30);
        run_random_phase(9'd1, 0, 65, 80, 50);
        run_random_phase(9'd300, 32, 32, 70, 40);

        wait_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        pressure_on <= 1'b1;
        repeat (10)
            send_item(random_item(70), 1'b0, '0);
        pressure_on <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge aclk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_ram.sv
hw/rtl/max_heap_priority_queue.sv
hw/rtl/mhpq_checker.sv
sim/max_heap_priority_queue_tb.sv
